>>> design/emmb_pkg.sv
// ----------------------------------------------------------------------------
// emmb_pkg
// shared constants, types and fixed-point helpers of the model matrix builder
// ----------------------------------------------------------------------------
`default_nettype none

package emmb_pkg;

	// cordic stage angles as 32-bit binary angles
	localparam logic [31:0] ATAN_BA [0:23] = '{
		32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
		32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
		32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
		32'd166886,    32'd83443,     32'd41722,     32'd20861,
		32'd10430,     32'd5215,      32'd2608,      32'd1304,
		32'd652,       32'd326,       32'd163,       32'd81
	};

	// cordic gain for n stages, scaled by 1e10
	localparam longint GAIN_E10 [0:23] = '{
		64'd7071067812, 64'd6324555320, 64'd6135719911, 64'd6088339125,
		64'd6076482563, 64'd6073517701, 64'd6072776441, 64'd6072591123,
		64'd6072544793, 64'd6072533211, 64'd6072530315, 64'd6072529591,
		64'd6072529410, 64'd6072529365, 64'd6072529354, 64'd6072529351,
		64'd6072529350, 64'd6072529350, 64'd6072529350, 64'd6072529350,
		64'd6072529350, 64'd6072529350, 64'd6072529350, 64'd6072529350
	};

	localparam longint E10 = 64'd10000000000;

	// angle to binary angle: floor(u / 45) by reciprocal, u offset to stay positive
	localparam logic [32:0] DEG_OFS      = 33'd2147483655; // 45 * DEG_OFS_K
	localparam logic [27:0] DEG_OFS_K    = 28'd47721859;
	localparam logic [34:0] RECIP45      = 35'd24433591729; // ceil(2^40 / 45)
	localparam int          RECIP45_SH   = 40;
	localparam logic [27:0] RECIP45_T    = 28'd190887436;  // ceil(2^33 / 45)
	localparam int          RECIP45_T_SH = 33;

	typedef struct packed {
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] pos_z;
		logic signed [31:0] scl_x;
		logic signed [31:0] scl_y;
		logic signed [31:0] scl_z;
	} side_t;

	typedef struct packed {
		logic signed [31:0] e0;
		logic signed [31:0] e1;
		logic signed [31:0] e2;
	} col_t;

	function automatic logic signed [33:0] gain_q30(input int n);
		longint g;
		g = (GAIN_E10[n - 1] * 64'd1073741824) / E10;
		return 34'(g);
	endfunction

	function automatic logic signed [31:0] sat64(input logic signed [63:0] v);
		logic signed [31:0] r;
		if (v > 64'sd2147483647) begin
			r = 32'sh7fffffff;
		end else if (v < -64'sd2147483648) begin
			r = 32'sh80000000;
		end else begin
			r = 32'(v);
		end
		return r;
	endfunction

	function automatic logic signed [31:0] sat34(input logic signed [33:0] v);
		return sat64(64'(v));
	endfunction

	// rounded fixed-point product, saturated
	function automatic logic signed [31:0] fmul(input logic signed [31:0] a,
			input logic signed [31:0] b, input int frac);
		logic signed [63:0] p;
		p = 64'(a) * 64'(b);
		p = p + (64'sd1 <<< (frac - 1));
		return sat64(p >>> frac);
	endfunction

endpackage

`default_nettype wire

>>> design/euler_model_matrix_builder.sv
// ----------------------------------------------------------------------------
// euler_model_matrix_builder
// model matrix T * Rx * Ry * Rz * S from position, euler angles and scale
// ----------------------------------------------------------------------------
//
// channel   handshake          payload
// -------   ----------------   ----------------------------------------------
// input     start / busy       pos_*, angle_*_deg, dim_*, uniform_scale
// result    done (strobe)      column_index, elem_row0..3, last_column
//
// one transfer is taken at a rising edge with start high and busy low
// busy stays high after a transfer while the spacing counter runs down, which
// keeps items apart so the four columns of each can share the single result channel
// column 0 follows the sine/cosine units, the combine stages and the result
// registers, the other columns follow in consecutive cycles
// reset clears only the valid bits, the spacing counter and the column sequencer
// the receiver cannot stall, so the pipeline never holds
`default_nettype none

module euler_model_matrix_builder #(
	parameter int FRAC_BITS     = 16,
	parameter int CORDIC_STAGES = 16
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	output logic                    busy,
	input  wire logic signed [31:0] pos_x,
	input  wire logic signed [31:0] pos_y,
	input  wire logic signed [31:0] pos_z,
	input  wire logic signed [31:0] angle_x_deg,
	input  wire logic signed [31:0] angle_y_deg,
	input  wire logic signed [31:0] angle_z_deg,
	input  wire logic signed [31:0] dim_x,
	input  wire logic signed [31:0] dim_y,
	input  wire logic signed [31:0] dim_z,
	input  wire logic signed [31:0] uniform_scale,
	output logic                    done,
	output logic [1:0]              column_index,
	output logic signed [31:0]      elem_row0,
	output logic signed [31:0]      elem_row1,
	output logic signed [31:0]      elem_row2,
	output logic signed [31:0]      elem_row3,
	output logic                    last_column
);

	localparam int NST = (CORDIC_STAGES < 1) ? 1 : ((CORDIC_STAGES > 24) ? 24 : CORDIC_STAGES);
	localparam int LS  = NST + 4;   // sine/cosine unit latency
	localparam int DL  = LS + 3;    // side data delay up to the scale stage
	localparam int LT  = LS + 4;    // total pipeline depth
	localparam logic signed [31:0] ONE = 32'sd1 <<< FRAC_BITS;

	logic accept;
	logic [1:0] gap_q;

	assign accept = start && !busy;
	assign busy   = (gap_q != 2'd0);

	// spacing counter: holds busy high after each accepted item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gap_q <= '0;
		end else if (accept) begin
			gap_q <= 2'd3;
		end else if (gap_q != 2'd0) begin
			gap_q <= gap_q - 2'd1;
		end
	end

	// valid bits alongside the data
	logic vld_s [1:LT];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 1; k <= LT; k++) begin
				vld_s[k] <= 1'b0;
			end
		end else begin
			vld_s[1] <= accept;
			for (int k = 2; k <= LT; k++) begin
				vld_s[k] <= vld_s[k - 1];
			end
		end
	end

	// three sine/cosine units in parallel
	logic signed [31:0] sx, cx, sy, cy, sz, cz;

	emmb_sincos #(.FRAC_BITS(FRAC_BITS), .CORDIC_STAGES(CORDIC_STAGES)) u_sc_x (
		.clk(clk), .angle(angle_x_deg), .sin_val(sx), .cos_val(cx)
	);
	emmb_sincos #(.FRAC_BITS(FRAC_BITS), .CORDIC_STAGES(CORDIC_STAGES)) u_sc_y (
		.clk(clk), .angle(angle_y_deg), .sin_val(sy), .cos_val(cy)
	);
	emmb_sincos #(.FRAC_BITS(FRAC_BITS), .CORDIC_STAGES(CORDIC_STAGES)) u_sc_z (
		.clk(clk), .angle(angle_z_deg), .sin_val(sz), .cos_val(cz)
	);

	// position and per-axis scale ride a delay line beside the cordic
	emmb_pkg::side_t side_s [1:DL];

	always_ff @(posedge clk) begin
		side_s[1].pos_x <= pos_x;
		side_s[1].pos_y <= pos_y;
		side_s[1].pos_z <= pos_z;
		side_s[1].scl_x <= emmb_pkg::fmul(dim_x, uniform_scale, FRAC_BITS);
		side_s[1].scl_y <= emmb_pkg::fmul(dim_y, uniform_scale, FRAC_BITS);
		side_s[1].scl_z <= emmb_pkg::fmul(dim_z, uniform_scale, FRAC_BITS);
		for (int k = 2; k <= DL; k++) begin
			side_s[k] <= side_s[k - 1];
		end
	end

	// combine stage 1: pairwise products
	logic signed [31:0] cycz_s1, cysz_s1, sxsy_s1, cxsy_s1, cxsz_s1;
	logic signed [31:0] cxcz_s1, sxsz_s1, sxcz_s1, sxcy_s1, cxcy_s1, sy_s1, cz_s1, sz_s1;

	always_ff @(posedge clk) begin
		cycz_s1 <= emmb_pkg::fmul(cy, cz, FRAC_BITS);
		cysz_s1 <= emmb_pkg::fmul(cy, sz, FRAC_BITS);
		sxsy_s1 <= emmb_pkg::fmul(sx, sy, FRAC_BITS);
		cxsy_s1 <= emmb_pkg::fmul(cx, sy, FRAC_BITS);
		cxsz_s1 <= emmb_pkg::fmul(cx, sz, FRAC_BITS);
		cxcz_s1 <= emmb_pkg::fmul(cx, cz, FRAC_BITS);
		sxsz_s1 <= emmb_pkg::fmul(sx, sz, FRAC_BITS);
		sxcz_s1 <= emmb_pkg::fmul(sx, cz, FRAC_BITS);
		sxcy_s1 <= emmb_pkg::fmul(sx, cy, FRAC_BITS);
		cxcy_s1 <= emmb_pkg::fmul(cx, cy, FRAC_BITS);
		sy_s1   <= sy;
		cz_s1   <= cz;
		sz_s1   <= sz;
	end

	// combine stage 2: triple products
	logic signed [31:0] ta_s2, tb_s2, tc_s2, td_s2;
	logic signed [31:0] cycz_s2, cysz_s2, cxsz_s2, cxcz_s2, sxsz_s2, sxcz_s2;
	logic signed [31:0] sxcy_s2, cxcy_s2, sy_s2;

	always_ff @(posedge clk) begin
		ta_s2   <= emmb_pkg::fmul(sxsy_s1, cz_s1, FRAC_BITS);
		tb_s2   <= emmb_pkg::fmul(sxsy_s1, sz_s1, FRAC_BITS);
		tc_s2   <= emmb_pkg::fmul(cxsy_s1, cz_s1, FRAC_BITS);
		td_s2   <= emmb_pkg::fmul(cxsy_s1, sz_s1, FRAC_BITS);
		cycz_s2 <= cycz_s1;
		cysz_s2 <= cysz_s1;
		cxsz_s2 <= cxsz_s1;
		cxcz_s2 <= cxcz_s1;
		sxsz_s2 <= sxsz_s1;
		sxcz_s2 <= sxcz_s1;
		sxcy_s2 <= sxcy_s1;
		cxcy_s2 <= cxcy_s1;
		sy_s2   <= sy_s1;
	end

	// combine stage 3: rotation matrix with saturating sums
	logic signed [31:0] rot_s3 [0:2][0:2];

	always_ff @(posedge clk) begin
		rot_s3[0][0] <= cycz_s2;
		rot_s3[0][1] <= emmb_pkg::sat34(-34'(cysz_s2));
		rot_s3[0][2] <= sy_s2;
		rot_s3[1][0] <= emmb_pkg::sat34(34'(ta_s2) + 34'(cxsz_s2));
		rot_s3[1][1] <= emmb_pkg::sat34(-34'(tb_s2) + 34'(cxcz_s2));
		rot_s3[1][2] <= emmb_pkg::sat34(-34'(sxcy_s2));
		rot_s3[2][0] <= emmb_pkg::sat34(-34'(tc_s2) + 34'(sxsz_s2));
		rot_s3[2][1] <= emmb_pkg::sat34(34'(td_s2) + 34'(sxcz_s2));
		rot_s3[2][2] <= cxcy_s2;
	end

	// combine stage 4: column scaling, translation column alongside
	emmb_pkg::col_t mat_s4 [0:3];
	logic signed [31:0] scl [0:2];

	assign scl[0] = side_s[DL].scl_x;
	assign scl[1] = side_s[DL].scl_y;
	assign scl[2] = side_s[DL].scl_z;

	always_ff @(posedge clk) begin
		for (int j = 0; j < 3; j++) begin
			mat_s4[j].e0 <= emmb_pkg::fmul(rot_s3[0][j], scl[j], FRAC_BITS);
			mat_s4[j].e1 <= emmb_pkg::fmul(rot_s3[1][j], scl[j], FRAC_BITS);
			mat_s4[j].e2 <= emmb_pkg::fmul(rot_s3[2][j], scl[j], FRAC_BITS);
		end
		mat_s4[3].e0 <= side_s[DL].pos_x;
		mat_s4[3].e1 <= side_s[DL].pos_y;
		mat_s4[3].e2 <= side_s[DL].pos_z;
	end

	// column sequencer: column 0 straight out, the rest held and sent in turn
	emmb_pkg::col_t hold_q [1:3];
	logic [1:0]     col_q;
	logic           act_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			act_q <= 1'b0;
			done  <= 1'b0;
		end else if (vld_s[LT]) begin
			col_q <= 2'd1;
			act_q <= 1'b1;
			done  <= 1'b1;
		end else if (act_q) begin
			col_q <= col_q + 2'd1;
			act_q <= (col_q != 2'd3);
			done  <= 1'b1;
		end else begin
			done  <= 1'b0;
		end
	end

	// payload of the result registers
	always_ff @(posedge clk) begin
		if (vld_s[LT]) begin
			for (int j = 1; j < 4; j++) begin
				hold_q[j] <= mat_s4[j];
			end
			column_index <= 2'd0;
			elem_row0    <= mat_s4[0].e0;
			elem_row1    <= mat_s4[0].e1;
			elem_row2    <= mat_s4[0].e2;
			elem_row3    <= '0;
			last_column  <= 1'b0;
		end else if (act_q) begin
			column_index <= col_q;
			elem_row0    <= hold_q[col_q].e0;
			elem_row1    <= hold_q[col_q].e1;
			elem_row2    <= hold_q[col_q].e2;
			elem_row3    <= (col_q == 2'd3) ? ONE : '0;
			last_column  <= (col_q == 2'd3);
		end
	end

	// checks
	a_busy_after_transfer: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> busy)
		else $error("busy low right after a transfer");

	a_item_spacing: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s[1] |-> !vld_s[2] && !vld_s[3] && !vld_s[4])
		else $error("items closer than four cycles in the pipeline");

	a_columns_contiguous: assert property (@(posedge clk) disable iff (!arst_n)
		done && !last_column |=> done && (column_index == $past(column_index) + 2'd1))
		else $error("column sequence broken");

	a_last_is_col3: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (last_column == (column_index == 2'd3)))
		else $error("last column flag out of step with index");

endmodule

`default_nettype wire

>>> design/emmb_sincos.sv
// ----------------------------------------------------------------------------
// emmb_sincos
// degree angle to binary angle, then pipelined rotation-mode cordic
// ----------------------------------------------------------------------------
`default_nettype none

module emmb_sincos #(
	parameter int FRAC_BITS     = 16,
	parameter int CORDIC_STAGES = 16
) (
	input  wire logic               clk,
	input  wire logic signed [31:0] angle,
	output logic signed [31:0]      sin_val,
	output logic signed [31:0]      cos_val
);

	localparam int NST  = (CORDIC_STAGES < 1) ? 1 : ((CORDIC_STAGES > 24) ? 24 : CORDIC_STAGES);
	localparam int SH_A = 29 - FRAC_BITS;
	localparam int SH_R = 30 - FRAC_BITS;
	localparam logic signed [33:0] RND = 34'sd1 <<< (29 - FRAC_BITS);

	// stage 1: quotient by 45
	logic [32:0] u;
	logic [67:0] prod1;
	logic [27:0] qe_s1;
	logic [32:0] u_s1;

	assign u     = 33'(angle) + emmb_pkg::DEG_OFS;
	assign prod1 = 68'(u) * 68'(emmb_pkg::RECIP45);

	always_ff @(posedge clk) begin
		qe_s1 <= prod1[emmb_pkg::RECIP45_SH +: 28];
		u_s1  <= u;
	end

	// stage 2: remainder and its scaled form
	logic [5:0]         rem;
	logic signed [27:0] a_s2;
	logic [27:0]        t_s2;

	assign rem = 6'(u_s1 - 33'(qe_s1) * 33'd45);

	always_ff @(posedge clk) begin
		a_s2 <= signed'(qe_s1 - emmb_pkg::DEG_OFS_K);
		t_s2 <= (28'(rem) << SH_A) + 28'd22;
	end

	// stage 3: binary angle and half-plane fold
	logic [55:0] prod2;
	logic [31:0] ba;
	logic [31:0] bt;
	logic [31:0] bf;

	assign prod2 = 56'(t_s2) * 56'(emmb_pkg::RECIP45_T);
	assign ba    = (32'(a_s2) << SH_A) + 32'(prod2 >> emmb_pkg::RECIP45_T_SH);
	assign bt    = ba + 32'h4000_0000;
	assign bf    = bt[31] ? (ba ^ 32'h8000_0000) : ba;

	logic signed [33:0] cx_s [0:NST];
	logic signed [33:0] cy_s [0:NST];
	logic signed [33:0] cz_s [0:NST];
	logic               cn_s [0:NST];

	always_ff @(posedge clk) begin
		cx_s[0] <= emmb_pkg::gain_q30(NST);
		cy_s[0] <= '0;
		cz_s[0] <= 34'(signed'(bf));
		cn_s[0] <= bt[31];
	end

	// cordic stages, one register each
	for (genvar i = 0; i < NST; i++) begin : g_cordic
		logic signed [33:0] dx;
		logic signed [33:0] dy;
		logic signed [33:0] da;
		assign dx = cy_s[i] >>> i;
		assign dy = cx_s[i] >>> i;
		assign da = 34'(emmb_pkg::ATAN_BA[i]);
		always_ff @(posedge clk) begin
			if (!cz_s[i][33]) begin
				cx_s[i + 1] <= cx_s[i] - dx;
				cy_s[i + 1] <= cy_s[i] + dy;
				cz_s[i + 1] <= cz_s[i] - da;
			end else begin
				cx_s[i + 1] <= cx_s[i] + dx;
				cy_s[i + 1] <= cy_s[i] - dy;
				cz_s[i + 1] <= cz_s[i] + da;
			end
			cn_s[i + 1] <= cn_s[i];
		end
	end

	// final stage: undo the fold and round to the output format
	logic signed [33:0] xo;
	logic signed [33:0] yo;
	logic signed [33:0] xr;
	logic signed [33:0] yr;

	assign xo = cn_s[NST] ? -cx_s[NST] : cx_s[NST];
	assign yo = cn_s[NST] ? -cy_s[NST] : cy_s[NST];
	assign xr = (xo + RND) >>> SH_R;
	assign yr = (yo + RND) >>> SH_R;

	always_ff @(posedge clk) begin
		cos_val <= 32'(xr);
		sin_val <= 32'(yr);
	end

endmodule

`default_nettype wire

>>> sim/tb.sv
// ----------------------------------------------------------------------------
// tb
// testbench of the euler model matrix builder: directed and random objects,
// every column checked against a cycle-free fixed-point predictor
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none

module tb;

	localparam int  FRAC      = 16;
	localparam int  STAGES    = 16;
	localparam int  LATENCY   = STAGES + 9 + 4;
	localparam int  CYCLE_CAP = 200000;
	localparam int  N_DIR     = 15;
	localparam int  N_RAND    = 270;

	// fixed-point shorthands
	localparam logic [31:0] ONE_Q  = 32'h0001_0000;
	localparam logic [31:0] MAX_Q  = 32'h7fff_ffff;
	localparam logic [31:0] MIN_Q  = 32'h8000_0000;
	localparam logic [31:0] NEG1_Q = 32'hffff_0000;
	localparam logic [31:0] D90    = 32'h005a_0000;
	localparam logic [31:0] D180   = 32'h00b4_0000;
	localparam logic [31:0] D270   = 32'h010e_0000;
	localparam logic [31:0] D360   = 32'h0168_0000;

	// one object as presented on the input ports
	typedef struct packed {
		logic [31:0] px, py, pz;
		logic [31:0] ax, ay, az;
		logic [31:0] dx, dy, dz;
		logic [31:0] scale;
	} object_t;

	// one column as it leaves the block
	typedef struct packed {
		logic [1:0]  idx;
		logic [31:0] r0, r1, r2, r3;
		logic        last;
	} column_t;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	logic signed [31:0] pos_x, pos_y, pos_z;
	logic signed [31:0] angle_x_deg, angle_y_deg, angle_z_deg;
	logic signed [31:0] dim_x, dim_y, dim_z, uniform_scale;
	logic done;
	logic [1:0] column_index;
	logic signed [31:0] elem_row0, elem_row1, elem_row2, elem_row3;
	logic last_column;

	euler_model_matrix_builder #(.FRAC_BITS(FRAC), .CORDIC_STAGES(STAGES)) dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
		.angle_x_deg(angle_x_deg), .angle_y_deg(angle_y_deg), .angle_z_deg(angle_z_deg),
		.dim_x(dim_x), .dim_y(dim_y), .dim_z(dim_z), .uniform_scale(uniform_scale),
		.done(done), .column_index(column_index),
		.elem_row0(elem_row0), .elem_row1(elem_row1), .elem_row2(elem_row2),
		.elem_row3(elem_row3), .last_column(last_column)
	);

	// columns still owed by the block, oldest first
	column_t pending_cols[$];
	int      errors;
	int      cycles;
	int      idle_pct;

	// cordic step angles as 32-bit binary angles
	longint step_angle [0:15] = '{
		536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
		10679838, 5340245, 2670163, 1335087, 667544, 333772,
		166886, 83443, 41722, 20861
	};

	// directed objects; rows with zero extent scale have columns 0..2 all zero
	// and column 3 equal to the position, so those are typed in directly
	object_t dir_tab [N_DIR] = '{
		'{ONE_Q, 32'hfffe_0000, 32'h0003_8000, 0, 0, 0, ONE_Q, ONE_Q, ONE_Q, 0},
		'{MAX_Q, MIN_Q, 0, D90, D180, D270, ONE_Q, ONE_Q, ONE_Q, 0},
		'{0, 0, 0, 0, 0, 0, MAX_Q, MIN_Q, ONE_Q, MAX_Q & 32'h0},
		'{ONE_Q, ONE_Q, ONE_Q, 0, 0, 0, ONE_Q, ONE_Q, ONE_Q, ONE_Q},
		'{0, 0, 0, D90, D90, D90, ONE_Q, ONE_Q, ONE_Q, ONE_Q},
		'{0, 0, 0, D180, D270, D360, ONE_Q, ONE_Q, ONE_Q, ONE_Q},
		'{0, 0, 0, -D90, -D180, -D360, ONE_Q, ONE_Q, ONE_Q, ONE_Q},
		'{0, 0, 0, MAX_Q, MIN_Q, 32'h002d_8000, ONE_Q, ONE_Q, ONE_Q, ONE_Q},
		'{0, 0, 0, 2 * D360, -2 * D360, 32'h0059_ffff, ONE_Q, ONE_Q, ONE_Q, ONE_Q},
		'{0, 0, 0, D270 - 1, D90 - 1, D180 - 1, ONE_Q, ONE_Q, ONE_Q, ONE_Q},
		'{0, 0, 0, 32'h001e_0000, 32'h002d_0000, 32'h003c_0000,
			MAX_Q, MAX_Q, MAX_Q, MAX_Q},
		'{0, 0, 0, 32'h001e_0000, 32'h002d_0000, 32'h003c_0000,
			MIN_Q, MIN_Q, MIN_Q, MIN_Q},
		'{0, 0, 0, 32'h0014_0000, 32'h00c8_0000, 32'h0136_0000,
			MIN_Q, MAX_Q, MIN_Q, NEG1_Q},
		'{MAX_Q, MIN_Q, 32'hffff_ffff, 32'hffd3_0000, 32'h0001_0000, 32'h00f0_0000,
			32'h0003_0000, 32'h0004_0000, 32'h0005_0000, 32'hfffd_8000},
		'{32'h1234_5678, 32'hedcb_a988, 1, D90, D90, D90, 0, 0, 0, MAX_Q}
	};
	bit dir_known [N_DIR] = '{1, 1, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1};

	// ---------------------------------------------------------------- predictor

	function automatic longint clip32(input longint v);
		if (v > 64'sd2147483647)
			return 64'sd2147483647;
		if (v < -64'sd2147483648)
			return -64'sd2147483648;
		return v;
	endfunction

	function automatic longint qmul(input longint a, input longint b);
		return clip32((a * b + (64'sd1 <<< (FRAC - 1))) >>> FRAC);
	endfunction

	// sine and cosine of an angle in degrees, through the folded cordic
	function automatic void deg_sin_cos(input logic [31:0] deg, output longint s,
			output longint c);
		longint full, r, z, x, y, dxs, dys;
		logic [31:0] b;
		bit flip;
		full = longint'(360) <<< FRAC;
		r = longint'($signed(deg)) % full;
		if (r < 0)
			r += full;
		b = 32'(((r <<< (32 - FRAC)) + 180) / 360);
		flip = 0;
		// second and third quadrant fold onto the first and fourth
		if (((b + 32'h4000_0000) & 32'h8000_0000) != 0) begin
			b = b - 32'h8000_0000;
			flip = 1;
		end
		z = longint'($signed(b));
		x = (64'd6072529351 * 64'd1073741824) / 64'd10000000000;
		y = 0;
		for (int i = 0; i < STAGES; i++) begin
			dxs = y >>> i;
			dys = x >>> i;
			if (z >= 0) begin
				x -= dxs;
				y += dys;
				z -= step_angle[i];
			end else begin
				x += dxs;
				y -= dys;
				z += step_angle[i];
			end
		end
		if (flip) begin
			x = -x;
			y = -y;
		end
		c = (x + (64'sd1 <<< (29 - FRAC))) >>> (30 - FRAC);
		s = (y + (64'sd1 <<< (29 - FRAC))) >>> (30 - FRAC);
	endfunction

	// push the four columns of T * Rx * Ry * Rz * S for one object
	task automatic predict_matrix(input object_t o);
		longint sx, cx, sy, cy, sz, cz, sxy, cxy, scl;
		longint rot [3][3];
		longint ext [3];
		column_t col;
		scl = longint'($signed(o.scale));
		ext[0] = qmul(longint'($signed(o.dx)), scl);
		ext[1] = qmul(longint'($signed(o.dy)), scl);
		ext[2] = qmul(longint'($signed(o.dz)), scl);
		deg_sin_cos(o.ax, sx, cx);
		deg_sin_cos(o.ay, sy, cy);
		deg_sin_cos(o.az, sz, cz);
		sxy = qmul(sx, sy);
		cxy = qmul(cx, sy);
		rot[0][0] = qmul(cy, cz);
		rot[0][1] = clip32(-qmul(cy, sz));
		rot[0][2] = sy;
		rot[1][0] = clip32(qmul(sxy, cz) + qmul(cx, sz));
		rot[1][1] = clip32(-qmul(sxy, sz) + qmul(cx, cz));
		rot[1][2] = clip32(-qmul(sx, cy));
		rot[2][0] = clip32(-qmul(cxy, cz) + qmul(sx, sz));
		rot[2][1] = clip32(qmul(cxy, sz) + qmul(sx, cz));
		rot[2][2] = qmul(cx, cy);
		for (int j = 0; j < 3; j++) begin
			col.idx  = 2'(j);
			col.r0   = 32'(qmul(rot[0][j], ext[j]));
			col.r1   = 32'(qmul(rot[1][j], ext[j]));
			col.r2   = 32'(qmul(rot[2][j], ext[j]));
			col.r3   = 0;
			col.last = 0;
			pending_cols.push_back(col);
		end
		pending_cols.push_back('{2'd3, o.px, o.py, o.pz, ONE_Q, 1'b1});
	endtask

	// zero extent: rotation columns vanish, translation column stays
	task automatic push_flat_matrix(input object_t o);
		for (int j = 0; j < 3; j++)
			pending_cols.push_back('{2'(j), 32'd0, 32'd0, 32'd0, 32'd0, 1'b0});
		pending_cols.push_back('{2'd3, o.px, o.py, o.pz, ONE_Q, 1'b1});
	endtask

	// ---------------------------------------------------------------- clock, reset

	always #1 clk = ~clk;

	initial begin
		clk = 0;
		arst_n = 0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1;
	end

	// watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_CAP) begin
			$display("FAILURE");
			$finish;
		end
	end

	// ---------------------------------------------------------------- result check

	always @(posedge clk) begin
		column_t exp_col;
		if (arst_n && done) begin
			if (pending_cols.size() == 0) begin
				errors++;
				$display("%0t: column %0d with no matrix pending", $time, column_index);
			end else begin
				exp_col = pending_cols.pop_front();
				if (column_index !== exp_col.idx) begin
					errors++;
					$display("%0t: column_index exp %0d got %0d", $time, exp_col.idx,
						column_index);
				end
				if (elem_row0 !== exp_col.r0) begin
					errors++;
					$display("%0t: col %0d row0 exp %h got %h", $time, exp_col.idx,
						exp_col.r0, elem_row0);
				end
				if (elem_row1 !== exp_col.r1) begin
					errors++;
					$display("%0t: col %0d row1 exp %h got %h", $time, exp_col.idx,
						exp_col.r1, elem_row1);
				end
				if (elem_row2 !== exp_col.r2) begin
					errors++;
					$display("%0t: col %0d row2 exp %h got %h", $time, exp_col.idx,
						exp_col.r2, elem_row2);
				end
				if (elem_row3 !== exp_col.r3) begin
					errors++;
					$display("%0t: col %0d row3 exp %h got %h", $time, exp_col.idx,
						exp_col.r3, elem_row3);
				end
				if (last_column !== exp_col.last) begin
					errors++;
					$display("%0t: col %0d last_column exp %b got %b", $time,
						exp_col.idx, exp_col.last, last_column);
				end
			end
		end
	end

	// ---------------------------------------------------------------- stimulus

	// present one object and hold it until the transfer; inputs move at negedge
	task automatic send_object(input object_t o, input bit known);
		// sender idles in each cycle with a probability of idle_pct percent
		while ($urandom_range(99) < idle_pct) begin
			start = 0;
			@(negedge clk);
		end
		pos_x = o.px;  pos_y = o.py;  pos_z = o.pz;
		angle_x_deg = o.ax;  angle_y_deg = o.ay;  angle_z_deg = o.az;
		dim_x = o.dx;  dim_y = o.dy;  dim_z = o.dz;
		uniform_scale = o.scale;
		start = 1;
		// busy is sampled before the edge updates it
		@(posedge clk);
		while (busy)
			@(posedge clk);
		if (known)
			push_flat_matrix(o);
		else
			predict_matrix(o);
		@(negedge clk);
		start = 0;
	endtask

	// angle: mostly a few turns either way, sometimes any 32-bit value
	function automatic logic [31:0] pick_angle();
		if ($urandom_range(3) == 0)
			return $urandom;
		return 32'($signed($urandom_range(32'h0b40_0000)) - 32'sh05a0_0000);
	endfunction

	// extent or scale: mostly moderate, sometimes full range for saturation
	function automatic logic [31:0] pick_extent();
		if ($urandom_range(4) == 0)
			return $urandom;
		return 32'($signed($urandom_range(32'h0100_0000)) - 32'sh0080_0000);
	endfunction

	function automatic object_t random_object();
		object_t o;
		o.px = $urandom;  o.py = $urandom;  o.pz = $urandom;
		o.ax = pick_angle();  o.ay = pick_angle();  o.az = pick_angle();
		o.dx = pick_extent();  o.dy = pick_extent();  o.dz = pick_extent();
		o.scale = pick_extent();
		return o;
	endfunction

	initial begin
		errors = 0;
		cycles = 0;
		idle_pct = 14;
		start = 0;
		pos_x = 0;  pos_y = 0;  pos_z = 0;
		angle_x_deg = 0;  angle_y_deg = 0;  angle_z_deg = 0;
		dim_x = 0;  dim_y = 0;  dim_z = 0;
		uniform_scale = 0;
		@(posedge arst_n);
		@(negedge clk);

		for (int k = 0; k < N_DIR; k++)
			send_object(dir_tab[k], dir_known[k]);

		// three phases of sender idling: light, heavy, none
		for (int k = 0; k < N_RAND; k++) begin
			if (k == N_RAND / 3)
				idle_pct = 60;
			if (k == 2 * N_RAND / 3)
				idle_pct = 0;
			// once, let the block drain completely before going on
			if (k == N_RAND / 2) begin
				while (pending_cols.size() != 0)
					@(negedge clk);
			end
			send_object(random_object(), 0);
		end

		while (pending_cols.size() != 0)
			@(negedge clk);
		repeat (LATENCY) @(negedge clk);

		if (errors == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

`default_nettype wire

>>> euler_model_matrix_builder.f
design/emmb_pkg.sv
design/emmb_sincos.sv
design/euler_model_matrix_builder.sv
sim/tb.sv
